### sv/lzwbe_pkg.sv
package lzwbe_pkg;

	localparam int DICT_ENTRIES_DEF = 4096;
	localparam int ROOT_CODES = 256;
	localparam int BYTE_W = 8;
	localparam int CODE_W = 12;
	localparam int WIDTH_W = 4;

	typedef enum logic [6:0] {
		S_CLR   = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RD    = 7'b0000100,
		S_CHK   = 7'b0001000,
		S_CMP   = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic probe_next;
		logic take_hit;
		logic emit_miss;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic first;
		logic last;
		logic range_live;
		logic slot_live;
		logic key_match;
		logic out_free;
	} sts_t;

endpackage

### sv/lzw_byte_encoder.sv
// lzw encoder taking one byte per transaction and producing zero, one or two codes,
// each tagged with its packing width (bit length of the next free code). dictionary
// lookup uses an open-addressed hash table of 2**(clog2(DICT_ENTRIES)+1) slots with
// linear probing; each probe is a slot read, an entry read and a compare, the compare
// skipped when the slot holds no code of this stream. the first byte of a stream needs
// no probe. a code waits while the output is stalled, and no new byte is taken until
// the current one is done. after reset every slot of the hash table is swept clear,
// during which no byte is taken. the last byte of a stream flushes the pending code
// with stream_done set and the dictionary restarts for the next stream.
module lzw_byte_encoder
	import lzwbe_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CODE_W-1:0]  code,
	output logic [WIDTH_W-1:0] code_width,
	output logic               stream_done
);

	cmd_t cmd;
	sts_t sts;

	lzwbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzwbe_dp #(
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code          (code),
		.code_width    (code_width),
		.stream_done   (stream_done)
	);

endmodule

### sv/lzwbe_ctrl.sv
module lzwbe_ctrl
	import lzwbe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (sts.first) state_d = sts.last ? S_FLUSH : S_IDLE;
				else state_d = S_CHK;
			end
			S_CHK: begin
				state_d = sts.range_live ? S_CMP : S_EMIT;
			end
			S_CMP: begin
				if (!sts.slot_live) begin
					state_d = S_EMIT;
				end else if (sts.key_match) begin
					cmd.take_hit = 1'b1;
					state_d = sts.last ? S_FLUSH : S_IDLE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_RD;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_miss = 1'b1;
					state_d = sts.last ? S_FLUSH : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

endmodule

### sv/lzwbe_dp.sv
module lzwbe_dp
	import lzwbe_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CODE_W-1:0]  code,
	output logic [WIDTH_W-1:0] code_width,
	output logic               stream_done
);

	localparam int CW = $clog2(DICT_ENTRIES);
	localparam int NW = CW + 1;
	localparam int HW = CW + 1;
	localparam int HSIZE = 2 ** HW;

	logic [CW-1:0]         hmem [HSIZE];
	logic [CW+BYTE_W-1:0]  dmem [DICT_ENTRIES];
	logic [HW-1:0]         bmem [DICT_ENTRIES];

	logic [HW-1:0]         clr_q;
	logic                  pvalid_q;
	logic [NW-1:0]         nfc_q;
	logic                  out_valid_q;

	logic [BYTE_W-1:0]     byte_q;
	logic                  last_q;
	logic                  first_q;
	logic [CW-1:0]         prefix_q;
	logic [HW-1:0]         haddr_q;
	logic [CW-1:0]         slot_q;
	logic [CW+BYTE_W-1:0]  dent_q;
	logic [HW-1:0]         back_q;
	logic [CODE_W-1:0]     out_code_q;
	logic [WIDTH_W-1:0]    out_w_q;
	logic                  out_done_q;

	logic                  can_insert;
	logic                  ins;
	logic                  out_free;
	logic [HW-1:0]         hash;
	logic [WIDTH_W-1:0]    nfc_len;

	assign can_insert = nfc_q < NW'(DICT_ENTRIES);
	assign ins = cmd.emit_miss && can_insert;
	assign out_free = !out_valid_q || !out_stall;
	assign hash = ({1'b0, prefix_q} << 1) ^ (HW'(data_byte) << (HW - BYTE_W));

	always_comb begin
		nfc_len = '0;
		for (int i = 0; i < NW; i++) begin
			if (nfc_q[i]) nfc_len = WIDTH_W'(i + 1);
		end
	end

	assign sts.clr_done = &clr_q;
	assign sts.first = first_q;
	assign sts.last = last_q;
	assign sts.range_live = ({1'b0, slot_q} >= NW'(ROOT_CODES)) && ({1'b0, slot_q} < nfc_q);
	assign sts.slot_live = (back_q == haddr_q);
	assign sts.key_match = (dent_q == {prefix_q, byte_q});
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pvalid_q <= 1'b0;
			nfc_q <= NW'(ROOT_CODES);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.accept) pvalid_q <= 1'b1;
			if (ins) nfc_q <= nfc_q + 1'b1;
			if (cmd.flush) begin
				nfc_q <= NW'(ROOT_CODES);
				pvalid_q <= 1'b0;
			end
			if (cmd.emit_miss || cmd.flush) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data_byte;
			last_q <= end_of_stream;
			first_q <= !pvalid_q;
			haddr_q <= hash;
			if (!pvalid_q) prefix_q <= CW'(data_byte);
		end
		if (cmd.probe_next) haddr_q <= haddr_q + 1'b1;
		if (cmd.take_hit) prefix_q <= slot_q;
		if (cmd.emit_miss) begin
			out_code_q <= CODE_W'(prefix_q);
			out_w_q <= nfc_len;
			out_done_q <= 1'b0;
			prefix_q <= CW'(byte_q);
		end
		if (cmd.flush) begin
			out_code_q <= CODE_W'(prefix_q);
			out_w_q <= nfc_len;
			out_done_q <= 1'b1;
			prefix_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) hmem[clr_q] <= '0;
		else if (ins) hmem[haddr_q] <= nfc_q[CW-1:0];
		slot_q <= hmem[haddr_q];
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			dmem[nfc_q[CW-1:0]] <= {prefix_q, byte_q};
			bmem[nfc_q[CW-1:0]] <= haddr_q;
		end
		dent_q <= dmem[slot_q];
		back_q <= bmem[slot_q];
	end

	assign out_valid = out_valid_q;
	assign code = out_code_q;
	assign code_width = out_w_q;
	assign stream_done = out_done_q;

endmodule

### bench/lzw_code_checker.sv
`timescale 1ns / 1ps

module lzw_code_checker
	import lzwbe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               end_of_stream,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [CODE_W-1:0]  code,
	input  logic [WIDTH_W-1:0] code_width,
	input  logic               stream_done,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic [CODE_W-1:0]  code;
		logic [WIDTH_W-1:0] width;
		logic               done;
	} code_rec_t;

	code_rec_t   expected_codes[$];
	int          learned[int];
	int          next_code;
	int          phrase;
	bit          phrase_live;

	function automatic int bit_len(input int v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	function automatic void push_code(input int c, input bit d);
		code_rec_t r;
		r.code = c[CODE_W-1:0];
		r.width = WIDTH_W'(bit_len(next_code));
		r.done = d;
		expected_codes = {expected_codes, r};
	endfunction

	function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic eos);
		int key;
		key = phrase * ROOT_CODES + b;
		if (!phrase_live) begin
			phrase = b;
			phrase_live = 1;
		end else if (learned.exists(key)) begin
			phrase = learned[key];
		end else begin
			push_code(phrase, 0);
			if (next_code < DICT_ENTRIES_DEF) begin
				learned[key] = next_code;
				next_code++;
			end
			phrase = b;
		end
		if (eos) begin
			push_code(phrase, 1);
			learned.delete();
			next_code = ROOT_CODES;
			phrase = 0;
			phrase_live = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		code_rec_t exp_rec;
		if (!arst_n) begin
			expected_codes.delete();
			learned.delete();
			next_code = ROOT_CODES;
			phrase = 0;
			phrase_live = 0;
			errors = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_byte(data_byte, end_of_stream);
			if (out_valid && !out_stall) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected code transaction: code %0d", code);
					errors++;
				end else begin
					exp_rec = expected_codes.pop_front();
					if (code !== exp_rec.code) begin
						$error("code: expected %0d, actual %0d", exp_rec.code, code);
						errors++;
					end
					if (code_width !== exp_rec.width) begin
						$error("code_width: expected %0d, actual %0d", exp_rec.width,
							code_width);
						errors++;
					end
					if (stream_done !== exp_rec.done) begin
						$error("stream_done: expected %0d, actual %0d", exp_rec.done,
							stream_done);
						errors++;
					end
				end
			end
		end
		pending = expected_codes.size();
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench
	import lzwbe_pkg::*;
();

	localparam int IDLE_LIMIT = 40000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [BYTE_W-1:0]  data_byte;
	logic               end_of_stream;
	logic               out_valid;
	logic               out_stall;
	logic [CODE_W-1:0]  code;
	logic [WIDTH_W-1:0] code_width;
	logic               stream_done;
	int                 errors;
	int                 pending;
	bit                 quiet;
	int                 stall_burst;
	int                 idle_cycles;
	int                 sent;

	lzw_byte_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code(code),
		.code_width(code_width),
		.stream_done(stream_done)
	);

	lzw_code_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code(code),
		.code_width(code_width),
		.stream_done(stream_done),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// receiver stall bursts
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 0;
		end else if (stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_burst = $urandom_range(0, 10);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_stream(input int len, input bit narrow);
		int base;
		logic [BYTE_W-1:0] b;
		base = $urandom_range(0, 252);
		for (int i = 0; i < len; i++) begin
			b = narrow ? BYTE_W'(base + $urandom_range(0, 3)) : BYTE_W'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	initial begin
		quiet = 0;
		stall_burst = 0;
		idle_cycles = 0;
		sent = 0;
		in_valid = 0;
		data_byte = 0;
		end_of_stream = 0;
		out_stall = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single-byte streams at the byte extremes
		send_byte(8'h00, 1);
		send_byte(8'hFF, 1);
		// repeated phrase: hits then a miss before the flush
		send_byte(8'h41, 0);
		send_byte(8'h42, 0);
		send_byte(8'h41, 0);
		send_byte(8'h42, 0);
		send_byte(8'h41, 0);
		send_byte(8'h42, 0);
		send_byte(8'h41, 0);
		send_byte(8'h43, 1);
		// flush right after a hit
		send_byte(8'h55, 0);
		send_byte(8'hAA, 0);
		send_byte(8'h55, 0);
		send_byte(8'hAA, 1);
		// run of one byte value
		for (int i = 0; i < 8; i++)
			send_byte(8'hFF, i == 7);

		// hold off until the encoder drains
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);

		while (sent < 400)
			send_stream($urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
				: $urandom_range(4, 60), $urandom_range(0, 2) != 0);
		// long stream grows the dictionary
		send_stream(300, 0);
		while (sent < 850)
			send_stream($urandom_range(1, 50), $urandom_range(0, 1));
		quiet = 1;
		while (sent < 1040)
			send_stream($urandom_range(1, 20), $urandom_range(0, 1));

		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
